FILE: hdl/eil4_pkg.sv
// Package for the Ethernet/IP/L4 header locator: parse phases, status codes,
// protocol constants and offset widths.
// No dependencies; the locator top level imports it.
package eil4_pkg;

    // Offsets and byte counts are carried on this many bits.
    localparam int OFS_W           = 15;
    // Bytes at or beyond this position are neither counted nor parsed.
    localparam int MAX_FRAME_BYTES = 16384;
    // Frames shorter than this are reported as too short.
    localparam int MIN_FRAME_BYTES = 15;

    // Fixed header sizes and field positions.
    localparam int ETH_HDR_BYTES   = 14;
    localparam int IPV6_HDR_BYTES  = 40;
    localparam int UDP_HDR_BYTES   = 8;
    localparam int ETH_TYPE_HI_POS = 12;
    localparam int ETH_TYPE_LO_POS = 13;
    localparam int IPV4_VIHL_POS   = 0;
    localparam int IPV4_PROTO_POS  = 9;
    localparam int IPV6_NEXT_POS   = 6;
    localparam int TCP_DOFF_POS    = 12;
    localparam int GRE_FLAGS_POS   = 0;
    localparam int GRE_TYPE_HI_POS = 2;
    localparam int GRE_TYPE_LO_POS = 3;
    localparam int IPV4_MIN_IHL    = 5;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [7:0] PROTO_GRE = 8'd47;

    // Header currently being walked.
    typedef enum logic [2:0] {
        PH_ETH  = 3'd0,
        PH_IPV4 = 3'd1,
        PH_IPV6 = 3'd2,
        PH_TCP  = 3'd3,
        PH_GRE  = 3'd4,
        PH_DONE = 3'd5
    } phase_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_ETH   = 3'd1,
        ST_TOO_SHORT = 3'd2,
        ST_BAD_ETYPE = 3'd3,
        ST_BAD_PROTO = 3'd4,
        ST_TRUNC     = 3'd5
    } status_t;

endpackage

FILE: hdl/eth_ip_l4_header_locator_unit.sv
// Top level of the Ethernet/IP/L4 header locator: input register, per-frame
// parse state and result register.
// Depends on eil4_pkg.
//
// Throughput: one frame byte per clock cycle, unless a last byte waits on a held result.
// A last-byte beat passes through the input register, and the result register takes
// its result when the beat leaves it; a held result can delay that step.
// A held result stalls only a following last byte; other bytes keep flowing.
// Reset (rst_n low, asynchronous) empties both registers and clears the parse state.
module eth_ip_l4_header_locator_unit
    import eil4_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // Byte input channel
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       frame_byte,
    input  logic             first_byte,
    input  logic             last_byte,
    input  logic             link_is_ethernet,
    // Result channel
    output logic             out_valid,
    input  logic             out_stall,
    output logic [2:0]       status,
    output logic             net_is_ipv6,
    output logic             transport_is_udp,
    output logic             gre_seen,
    output logic [OFS_W-1:0] ip_offset,
    output logic [OFS_W-1:0] transport_offset,
    output logic [OFS_W-1:0] payload_start,
    output logic [OFS_W-1:0] payload_length
);

    // Input register
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_first_reg;
    logic       s1_last_reg;
    logic       s1_link_reg;
    logic       s1_go;
    logic       in_take;

    // Parse state
    logic [OFS_W-1:0] pos_reg, pos_next;
    phase_t           phase_reg, phase_next;
    logic [OFS_W-1:0] hdr_reg, hdr_next;
    logic [7:0]       hi_reg, hi_next;
    logic [3:0]       ihl_reg, ihl_next;
    logic [3:0]       gflag_reg, gflag_next;
    status_t          err_reg, err_next;
    logic [OFS_W-1:0] ip_off_reg, ip_off_next;
    logic [OFS_W-1:0] tp_off_reg, tp_off_next;
    logic [OFS_W-1:0] pl_off_reg, pl_off_next;
    logic             v6_reg, v6_next;
    logic             udp_reg, udp_next;
    logic             gre_reg, gre_next;

    // Result register
    logic             out_valid_reg, out_valid_next;
    status_t          res_status_reg, res_status_next;
    logic             res_v6_reg, res_v6_next;
    logic             res_udp_reg, res_udp_next;
    logic             res_gre_reg, res_gre_next;
    logic [OFS_W-1:0] res_ip_reg, res_ip_next;
    logic [OFS_W-1:0] res_tp_reg, res_tp_next;
    logic [OFS_W-1:0] res_pl_reg, res_pl_next;
    logic [OFS_W-1:0] res_len_reg, res_len_next;

    // Handshake: only a last byte has to wait for a held result.
    assign s1_go    = s1_valid_reg && !(s1_last_reg && out_valid_reg && out_stall);
    assign in_stall = s1_valid_reg && !s1_go;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg  <= frame_byte;
            s1_first_reg <= first_byte;
            s1_last_reg  <= last_byte;
            s1_link_reg  <= link_is_ethernet;
        end
    end

    // One parse step for the byte in the input register.
    always_comb
    begin
        logic [OFS_W-1:0] pos_cur;
        logic [OFS_W-1:0] rel;
        logic [15:0]      word;
        logic [2:0]       gre_words;
        logic [4:0]       gre_len;
        logic             ip_fire;
        logic [OFS_W-1:0] ip_start;
        logic             tp_fire;
        logic [OFS_W-1:0] tp_start;
        logic [OFS_W-1:0] len;

        // A first marker starts the frame over.
        if (s1_first_reg)
        begin
            pos_cur     = '0;
            phase_next  = PH_ETH;
            hdr_next    = '0;
            err_next    = ST_OK;
            ip_off_next = '0;
            tp_off_next = '0;
            pl_off_next = '0;
            v6_next     = 1'b0;
            udp_next    = 1'b0;
            gre_next    = 1'b0;
        end
        else
        begin
            pos_cur     = pos_reg;
            phase_next  = phase_reg;
            hdr_next    = hdr_reg;
            err_next    = err_reg;
            ip_off_next = ip_off_reg;
            tp_off_next = tp_off_reg;
            pl_off_next = pl_off_reg;
            v6_next     = v6_reg;
            udp_next    = udp_reg;
            gre_next    = gre_reg;
        end
        hi_next    = hi_reg;
        ihl_next   = ihl_reg;
        gflag_next = gflag_reg;
        pos_next   = pos_cur;

        rel       = pos_cur - hdr_next;
        word      = {hi_reg, s1_byte_reg};
        gre_words = 3'(gflag_reg[3] | gflag_reg[2]) + 3'(gflag_reg[2])
                  + 3'(gflag_reg[1]) + 3'(gflag_reg[0]);
        gre_len   = {gre_words, 2'b00} + 5'd4;
        ip_fire   = 1'b0;
        ip_start  = '0;
        tp_fire   = 1'b0;
        tp_start  = '0;

        // Link type is sampled on the frame's first byte.
        if (pos_cur == '0)
        begin
            err_next = s1_link_reg ? ST_OK : ST_NOT_ETH;
        end

        if (pos_cur < OFS_W'(MAX_FRAME_BYTES))
        begin
            pos_next = pos_cur + OFS_W'(1);
            if (err_next == ST_OK && phase_next != PH_DONE && pos_cur >= hdr_next)
            begin
                unique case (phase_next)
                    PH_ETH:
                    begin
                        if (rel == OFS_W'(ETH_TYPE_HI_POS))
                        begin
                            hi_next = s1_byte_reg;
                        end
                        else if (rel == OFS_W'(ETH_TYPE_LO_POS))
                        begin
                            if (word == ETYPE_IPV4 || word == ETYPE_IPV6)
                            begin
                                ip_fire  = 1'b1;
                                ip_start = OFS_W'(ETH_HDR_BYTES);
                            end
                            else
                            begin
                                err_next = ST_BAD_ETYPE;
                            end
                        end
                    end
                    PH_IPV4:
                    begin
                        if (rel == OFS_W'(IPV4_VIHL_POS))
                        begin
                            if (s1_byte_reg[3:0] < 4'(IPV4_MIN_IHL))
                            begin
                                err_next = ST_BAD_PROTO;
                            end
                            else
                            begin
                                ihl_next = s1_byte_reg[3:0];
                            end
                        end
                        else if (rel == OFS_W'(IPV4_PROTO_POS))
                        begin
                            tp_fire  = 1'b1;
                            tp_start = hdr_next + OFS_W'({ihl_reg, 2'b00});
                        end
                    end
                    PH_IPV6:
                    begin
                        if (rel == OFS_W'(IPV6_NEXT_POS))
                        begin
                            tp_fire  = 1'b1;
                            tp_start = hdr_next + OFS_W'(IPV6_HDR_BYTES);
                        end
                    end
                    PH_TCP:
                    begin
                        if (rel == OFS_W'(TCP_DOFF_POS))
                        begin
                            pl_off_next = hdr_next + OFS_W'({s1_byte_reg[7:4], 2'b00});
                            phase_next  = PH_DONE;
                        end
                    end
                    PH_GRE:
                    begin
                        if (rel == OFS_W'(GRE_FLAGS_POS))
                        begin
                            gflag_next = s1_byte_reg[7:4];
                        end
                        else if (rel == OFS_W'(GRE_TYPE_HI_POS))
                        begin
                            hi_next = s1_byte_reg;
                        end
                        else if (rel == OFS_W'(GRE_TYPE_LO_POS))
                        begin
                            if (word == ETYPE_IPV4 || word == ETYPE_IPV6)
                            begin
                                ip_fire  = 1'b1;
                                ip_start = hdr_next + OFS_W'(gre_len);
                            end
                            else
                            begin
                                err_next = ST_BAD_PROTO;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        // Entering an IP header, outer or tunneled.
        if (ip_fire)
        begin
            hdr_next    = ip_start;
            ip_off_next = ip_start;
            v6_next     = (word == ETYPE_IPV6);
            phase_next  = (word == ETYPE_IPV6) ? PH_IPV6 : PH_IPV4;
        end

        // Entering the header selected by the IP protocol field.
        if (tp_fire)
        begin
            hdr_next = tp_start;
            if (s1_byte_reg == PROTO_TCP)
            begin
                tp_off_next = tp_start;
                udp_next    = 1'b0;
                phase_next  = PH_TCP;
            end
            else if (s1_byte_reg == PROTO_UDP)
            begin
                tp_off_next = tp_start;
                udp_next    = 1'b1;
                pl_off_next = tp_start + OFS_W'(UDP_HDR_BYTES);
                phase_next  = PH_DONE;
            end
            else if (s1_byte_reg == PROTO_GRE)
            begin
                gre_next   = 1'b1;
                phase_next = PH_GRE;
            end
            else
            begin
                err_next = ST_BAD_PROTO;
            end
        end

        // Frame verdict, used only when this is the last byte.
        len = pos_next;
        priority if (err_next == ST_NOT_ETH)
        begin
            res_status_next = ST_NOT_ETH;
        end
        else if (len < OFS_W'(MIN_FRAME_BYTES))
        begin
            res_status_next = ST_TOO_SHORT;
        end
        else if (err_next != ST_OK)
        begin
            res_status_next = err_next;
        end
        else if (phase_next != PH_DONE || pl_off_next > len)
        begin
            res_status_next = ST_TRUNC;
        end
        else
        begin
            res_status_next = ST_OK;
        end

        if (res_status_next == ST_OK)
        begin
            res_v6_next  = v6_next;
            res_udp_next = udp_next;
            res_gre_next = gre_next;
            res_ip_next  = ip_off_next;
            res_tp_next  = tp_off_next;
            res_pl_next  = pl_off_next;
            res_len_next = len - pl_off_next;
        end
        else
        begin
            res_v6_next  = 1'b0;
            res_udp_next = 1'b0;
            res_gre_next = 1'b0;
            res_ip_next  = '0;
            res_tp_next  = '0;
            res_pl_next  = '0;
            res_len_next = '0;
        end
    end

    // Parse state register; a last byte leaves it cleared for the next frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            phase_reg  <= PH_ETH;
            hdr_reg    <= '0;
            hi_reg     <= '0;
            ihl_reg    <= '0;
            gflag_reg  <= '0;
            err_reg    <= ST_OK;
            ip_off_reg <= '0;
            tp_off_reg <= '0;
            pl_off_reg <= '0;
            v6_reg     <= 1'b0;
            udp_reg    <= 1'b0;
            gre_reg    <= 1'b0;
        end
        else if (s1_go)
        begin
            if (s1_last_reg)
            begin
                pos_reg    <= '0;
                phase_reg  <= PH_ETH;
                hdr_reg    <= '0;
                err_reg    <= ST_OK;
                ip_off_reg <= '0;
                tp_off_reg <= '0;
                pl_off_reg <= '0;
                v6_reg     <= 1'b0;
                udp_reg    <= 1'b0;
                gre_reg    <= 1'b0;
            end
            else
            begin
                pos_reg    <= pos_next;
                phase_reg  <= phase_next;
                hdr_reg    <= hdr_next;
                err_reg    <= err_next;
                ip_off_reg <= ip_off_next;
                tp_off_reg <= tp_off_next;
                pl_off_reg <= pl_off_next;
                v6_reg     <= v6_next;
                udp_reg    <= udp_next;
                gre_reg    <= gre_next;
            end
            hi_reg    <= hi_next;
            ihl_reg   <= ihl_next;
            gflag_reg <= gflag_next;
        end
    end

    // Result register: loaded by a last byte, emptied when the beat is taken.
    assign out_valid_next = (s1_go && s1_last_reg) || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_last_reg)
        begin
            res_status_reg <= res_status_next;
            res_v6_reg     <= res_v6_next;
            res_udp_reg    <= res_udp_next;
            res_gre_reg    <= res_gre_next;
            res_ip_reg     <= res_ip_next;
            res_tp_reg     <= res_tp_next;
            res_pl_reg     <= res_pl_next;
            res_len_reg    <= res_len_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = res_status_reg;
    assign net_is_ipv6      = res_v6_reg;
    assign transport_is_udp = res_udp_reg;
    assign gre_seen         = res_gre_reg;
    assign ip_offset        = res_ip_reg;
    assign transport_offset = res_tp_reg;
    assign payload_start    = res_pl_reg;
    assign payload_length   = res_len_reg;

    // Only a last byte waiting on a held result may block the input.
    a_stall_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s1_last_reg && out_valid_reg))
        else $error("input stalled without a last byte waiting on the result");

    // A failed frame carries no header information.
    a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |->
            (!net_is_ipv6 && !transport_is_udp && !gre_seen && ip_offset == '0
             && transport_offset == '0 && payload_start == '0 && payload_length == '0))
        else $error("error result with nonzero fields");

    // On success the headers are ordered and the IP header has its minimum size.
    a_ok_ordering: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OK) |->
            ({1'b0, transport_offset} >= {1'b0, ip_offset} + 16'd20
             && payload_start >= transport_offset))
        else $error("header offsets out of order in a good result");

    // A result is only produced by a last byte that left the input register.
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s1_valid_reg && s1_last_reg))
        else $error("result appeared without a last byte");

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the Ethernet/IP/L4 header locator.
// Depends on eil4_pkg and eth_ip_l4_header_locator_unit; it needs no other files.
module tb;
    import eil4_pkg::*;

    localparam int OW          = OFS_W + 1;
    localparam int CYCLE_LIMIT = 600000;

    typedef logic [7:0] octet_q_t[$];

    // One frame summary as it appears on the result channel.
    typedef struct {
        logic [2:0]       st;
        logic             v6;
        logic             udp;
        logic             gre;
        logic [OFS_W-1:0] ipo;
        logic [OFS_W-1:0] l4o;
        logic [OFS_W-1:0] payo;
        logic [OFS_W-1:0] plen;
    } frame_layout_t;

    // Tracks the header walk of the frame in flight and holds the layouts still owed.
    class frame_layout_tracker;
        frame_layout_t    layouts_due[$];
        int               errors;
        int               layouts_noted;
        logic [OFS_W-1:0] byte_pos;
        phase_t           phase;
        logic [OW-1:0]    hdr_start;
        logic [15:0]      capture;
        logic [15:0]      gre_word;
        status_t          err_code;
        logic [OW-1:0]    ip_ofs;
        logic [OW-1:0]    l4_ofs;
        logic [OW-1:0]    pay_ofs;
        logic             is_v6;
        logic             is_udp;
        logic             via_gre;

        function new();
            errors        = 0;
            layouts_noted = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            byte_pos  = '0;
            phase     = PH_ETH;
            hdr_start = '0;
            capture   = '0;
            gre_word  = '0;
            err_code  = ST_OK;
            ip_ofs    = '0;
            l4_ofs    = '0;
            pay_ofs   = '0;
            is_v6     = 1'b0;
            is_udp    = 1'b0;
            via_gre   = 1'b0;
        endfunction

        function void enter_ip(logic [15:0] etype, logic [OW-1:0] start);
            hdr_start = start;
            ip_ofs    = start;
            if (etype == ETYPE_IPV4)
            begin
                phase = PH_IPV4;
                is_v6 = 1'b0;
            end
            else
            begin
                phase = PH_IPV6;
                is_v6 = 1'b1;
            end
        endfunction

        function void enter_transport(logic [7:0] proto, logic [OW-1:0] start);
            hdr_start = start;
            if (proto == PROTO_TCP)
            begin
                l4_ofs = start;
                is_udp = 1'b0;
                phase  = PH_TCP;
            end
            else if (proto == PROTO_UDP)
            begin
                l4_ofs  = start;
                is_udp  = 1'b1;
                pay_ofs = start + OW'(UDP_HDR_BYTES);
                phase   = PH_DONE;
            end
            else if (proto == PROTO_GRE)
            begin
                via_gre  = 1'b1;
                gre_word = '0;
                phase    = PH_GRE;
            end
            else
            begin
                err_code = ST_BAD_PROTO;
            end
        endfunction

        function void parse_byte(logic [7:0] b, logic [OW-1:0] rel);
            logic [15:0]   word;
            logic [OW-1:0] gre_len;
            unique case (phase)
                PH_ETH:
                begin
                    if (rel == OW'(ETH_TYPE_HI_POS))
                        capture = {b, 8'h00};
                    else if (rel == OW'(ETH_TYPE_LO_POS))
                    begin
                        word = capture | {8'h00, b};
                        if (word == ETYPE_IPV4 || word == ETYPE_IPV6)
                            enter_ip(word, OW'(ETH_HDR_BYTES));
                        else
                            err_code = ST_BAD_ETYPE;
                    end
                end
                PH_IPV4:
                begin
                    if (rel == OW'(IPV4_VIHL_POS))
                    begin
                        if (int'(b[3:0]) < IPV4_MIN_IHL)
                            err_code = ST_BAD_PROTO;
                        else
                            capture = {10'd0, b[3:0], 2'b00};
                    end
                    else if (rel == OW'(IPV4_PROTO_POS))
                        enter_transport(b, hdr_start + capture);
                end
                PH_IPV6:
                begin
                    if (rel == OW'(IPV6_NEXT_POS))
                        enter_transport(b, hdr_start + OW'(IPV6_HDR_BYTES));
                end
                PH_TCP:
                begin
                    if (rel == OW'(TCP_DOFF_POS))
                    begin
                        pay_ofs = hdr_start + OW'({b[7:4], 2'b00});
                        phase   = PH_DONE;
                    end
                end
                PH_GRE:
                begin
                    if (rel == OW'(GRE_FLAGS_POS))
                        gre_word = {b, 8'h00};
                    else if (rel == OW'(GRE_FLAGS_POS + 1))
                        gre_word = gre_word | {8'h00, b};
                    else if (rel == OW'(GRE_TYPE_HI_POS))
                        capture = {b, 8'h00};
                    else if (rel == OW'(GRE_TYPE_LO_POS))
                    begin
                        word    = capture | {8'h00, b};
                        // Base word plus one 32-bit field for C or R, and one more each for R, K and S.
                        gre_len = OW'(4);
                        if ((gre_word & 16'hC000) != 0)
                            gre_len = gre_len + OW'(4);
                        if (gre_word[14])
                            gre_len = gre_len + OW'(4);
                        if (gre_word[13])
                            gre_len = gre_len + OW'(4);
                        if (gre_word[12])
                            gre_len = gre_len + OW'(4);
                        if (word == ETYPE_IPV4 || word == ETYPE_IPV6)
                            enter_ip(word, hdr_start + gre_len);
                        else
                            err_code = ST_BAD_PROTO;
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        // Advance the walk by one accepted input beat; a last byte owes one layout.
        function void note_beat(logic [7:0] b, logic first, logic last, logic eth);
            logic [OFS_W-1:0] pos;
            logic [OW-1:0]    len;
            status_t          st;
            frame_layout_t    lay;
            if (first)
                clear_frame();
            pos = byte_pos;
            if (pos == '0)
                err_code = eth ? ST_OK : ST_NOT_ETH;
            if (int'(pos) < MAX_FRAME_BYTES)
            begin
                if (err_code == ST_OK && phase != PH_DONE && OW'(pos) >= hdr_start)
                    parse_byte(b, OW'(pos) - hdr_start);
                byte_pos = pos + OFS_W'(1);
            end
            if (last)
            begin
                len = OW'(byte_pos);
                if (err_code == ST_NOT_ETH)
                    st = ST_NOT_ETH;
                else if (int'(len) < MIN_FRAME_BYTES)
                    st = ST_TOO_SHORT;
                else if (err_code != ST_OK)
                    st = err_code;
                else if (phase != PH_DONE || pay_ofs > len)
                    st = ST_TRUNC;
                else
                    st = ST_OK;
                lay.st   = st;
                lay.v6   = 1'b0;
                lay.udp  = 1'b0;
                lay.gre  = 1'b0;
                lay.ipo  = '0;
                lay.l4o  = '0;
                lay.payo = '0;
                lay.plen = '0;
                if (st == ST_OK)
                begin
                    lay.v6   = is_v6;
                    lay.udp  = is_udp;
                    lay.gre  = via_gre;
                    lay.ipo  = OFS_W'(ip_ofs);
                    lay.l4o  = OFS_W'(l4_ofs);
                    lay.payo = OFS_W'(pay_ofs);
                    lay.plen = OFS_W'(len - pay_ofs);
                end
                layouts_due.push_back(lay);
                layouts_noted++;
                clear_frame();
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one accepted result beat with the oldest layout owed.
        function void check_layout(frame_layout_t got);
            frame_layout_t want;
            if (layouts_due.size() == 0)
            begin
                $display("%0t: unexpected result beat: expected none, actual status %0d",
                         $time, got.st);
                errors++;
                return;
            end
            want = layouts_due.pop_front();
            compare_field("status", want.st, got.st);
            compare_field("net_is_ipv6", want.v6, got.v6);
            compare_field("transport_is_udp", want.udp, got.udp);
            compare_field("gre_seen", want.gre, got.gre);
            compare_field("ip_offset", want.ipo, got.ipo);
            compare_field("transport_offset", want.l4o, got.l4o);
            compare_field("payload_start", want.payo, got.payo);
            compare_field("payload_length", want.plen, got.plen);
        endfunction

        function int pending();
            return layouts_due.size();
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [7:0]       frame_byte;
    logic             first_byte;
    logic             last_byte;
    logic             link_is_ethernet;
    logic             out_valid;
    logic             out_stall;
    logic [2:0]       status;
    logic             net_is_ipv6;
    logic             transport_is_udp;
    logic             gre_seen;
    logic [OFS_W-1:0] ip_offset;
    logic [OFS_W-1:0] transport_offset;
    logic [OFS_W-1:0] payload_start;
    logic [OFS_W-1:0] payload_length;

    frame_layout_tracker tracker;
    bit                  quiet;
    int                  hold_req;
    int                  bytes_sent;
    int                  cycle_count = 0;

    eth_ip_l4_header_locator_unit i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .frame_byte       (frame_byte),
        .first_byte       (first_byte),
        .last_byte        (last_byte),
        .link_is_ethernet (link_is_ethernet),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .net_is_ipv6      (net_is_ipv6),
        .transport_is_udp (transport_is_udp),
        .gre_seen         (gre_seen),
        .ip_offset        (ip_offset),
        .transport_offset (transport_offset),
        .payload_start    (payload_start),
        .payload_length   (payload_length)
    );

    // Free-running clock, period 10.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run-length guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Frame builders: most append one header with random filler.
    function automatic logic [7:0] rand_octet();
        return 8'($urandom);
    endfunction

    function automatic void put_random(ref octet_q_t q, input int n);
        for (int i = 0; i < n; i++)
            q.push_back(rand_octet());
    endfunction

    function automatic void put_eth(ref octet_q_t q, input logic [15:0] etype);
        put_random(q, ETH_TYPE_HI_POS);
        q.push_back(etype[15:8]);
        q.push_back(etype[7:0]);
    endfunction

    function automatic void put_ipv4(ref octet_q_t q, input int ihl, input logic [7:0] proto);
        int n;
        n = (ihl < IPV4_MIN_IHL) ? 20 : ihl * 4;
        q.push_back({4'h4, 4'(ihl)});
        put_random(q, IPV4_PROTO_POS - 1);
        q.push_back(proto);
        put_random(q, n - IPV4_PROTO_POS - 1);
    endfunction

    function automatic void put_ipv6(ref octet_q_t q, input logic [7:0] next_hdr);
        q.push_back({4'h6, 4'($urandom)});
        put_random(q, IPV6_NEXT_POS - 1);
        q.push_back(next_hdr);
        put_random(q, IPV6_HDR_BYTES - IPV6_NEXT_POS - 1);
    endfunction

    function automatic void put_gre(ref octet_q_t q, input logic [15:0] flags,
                                    input logic [15:0] ptype);
        int extra;
        extra = ((flags & 16'hC000) != 0) + flags[14] + flags[13] + flags[12];
        q.push_back(flags[15:8]);
        q.push_back(flags[7:0]);
        q.push_back(ptype[15:8]);
        q.push_back(ptype[7:0]);
        put_random(q, 4 * extra);
    endfunction

    function automatic void put_tcp(ref octet_q_t q, input int doff);
        int n;
        n = (doff * 4 > 20) ? doff * 4 : 20;
        for (int i = 0; i < n; i++)
            q.push_back((i == TCP_DOFF_POS) ? {4'(doff), 4'($urandom)} : rand_octet());
    endfunction

    function automatic void put_udp(ref octet_q_t q);
        put_random(q, UDP_HDR_BYTES);
    endfunction

    function automatic void cut_to(ref octet_q_t q, input int n);
        while (q.size() > n)
            void'(q.pop_back());
    endfunction

    // Mostly well-formed header stacks with random content, some tunneled,
    // some malformed, some cut short.
    function automatic void build_frame(ref octet_q_t q);
        int          pick;
        bit          v4;
        logic [7:0]  proto;
        logic [15:0] etype;
        logic [15:0] ptype;
        q.delete();
        pick = $urandom_range(99);
        if (pick < 45)
            etype = ETYPE_IPV4;
        else if (pick < 90)
            etype = ETYPE_IPV6;
        else
            etype = 16'($urandom);
        put_eth(q, etype);
        v4 = (etype == ETYPE_IPV4);
        if (etype == ETYPE_IPV4 || etype == ETYPE_IPV6)
        begin
            for (int depth = 0; depth < 4; depth++)
            begin
                pick = $urandom_range(99);
                if (pick < 35)
                    proto = PROTO_TCP;
                else if (pick < 70)
                    proto = PROTO_UDP;
                else if (pick < 92 && depth < 3)
                    proto = PROTO_GRE;
                else
                    proto = rand_octet();
                if (v4)
                    put_ipv4(q, ($urandom_range(19) == 0) ? $urandom_range(4)
                                                          : $urandom_range(15, 5), proto);
                else
                    put_ipv6(q, proto);
                if (proto == PROTO_GRE)
                begin
                    pick = $urandom_range(99);
                    if (pick < 45)
                        ptype = ETYPE_IPV4;
                    else if (pick < 90)
                        ptype = ETYPE_IPV6;
                    else
                        ptype = 16'($urandom);
                    put_gre(q, 16'($urandom), ptype);
                    if (ptype != ETYPE_IPV4 && ptype != ETYPE_IPV6)
                        break;
                    v4 = (ptype == ETYPE_IPV4);
                end
                else
                begin
                    if (proto == PROTO_TCP)
                        put_tcp(q, ($urandom_range(9) == 0) ? $urandom_range(4)
                                                            : $urandom_range(15, 5));
                    else if (proto == PROTO_UDP)
                        put_udp(q);
                    break;
                end
            end
        end
        put_random(q, $urandom_range(24));
        if ($urandom_range(99) < 15)
            cut_to(q, $urandom_range(q.size(), 1));
    endfunction

    // Offer one input beat, with a random idle gap first unless quiet, and hold it until accepted.
    task automatic send_beat(logic [7:0] b, logic f, logic l, logic e);
        while (!quiet && $urandom_range(99) < 25)
        begin
            in_valid         <= 1'b0;
            frame_byte       <= rand_octet();
            first_byte       <= 1'($urandom);
            last_byte        <= 1'($urandom);
            link_is_ethernet <= 1'($urandom);
            @(negedge clk);
        end
        in_valid         <= 1'b1;
        frame_byte       <= b;
        first_byte       <= f;
        last_byte        <= l;
        link_is_ethernet <= e;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_beat(b, f, l, e);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Link type only matters on the first byte; later beats carry noise there.
    task automatic send_frame(ref octet_q_t q, input bit mark_first, input bit on_ethernet,
                              input bit mark_last);
        for (int i = 0; i < q.size(); i++)
            send_beat(q[i], mark_first && i == 0, mark_last && i == q.size() - 1,
                      (i == 0) ? on_ethernet : 1'($urandom));
    endtask

    task automatic send_directed_frames();
        octet_q_t q;
        // Unmarked start right after reset, IPv4/TCP.
        q.delete();
        put_eth(q, ETYPE_IPV4); put_ipv4(q, 5, PROTO_TCP); put_tcp(q, 5); put_random(q, 6);
        send_frame(q, 0, 1, 1);
        // IPv4/UDP with no payload: payload offset equals the frame length.
        q.delete();
        put_eth(q, ETYPE_IPV4); put_ipv4(q, 5, PROTO_UDP); put_udp(q);
        send_frame(q, 1, 1, 1);
        // IPv6/TCP with the largest data offset.
        q.delete();
        put_eth(q, ETYPE_IPV6); put_ipv6(q, PROTO_TCP); put_tcp(q, 15); put_random(q, 3);
        send_frame(q, 1, 1, 1);
        // Largest IHL, TCP data offset below five.
        q.delete();
        put_eth(q, ETYPE_IPV4); put_ipv4(q, 15, PROTO_TCP); put_tcp(q, 2); put_random(q, 4);
        send_frame(q, 1, 1, 1);
        // IHL below five is a malformed header.
        q.delete();
        put_eth(q, ETYPE_IPV4); put_ipv4(q, 4, PROTO_TCP); put_tcp(q, 5);
        send_frame(q, 1, 1, 1);
        // Unknown EtherType, then unknown IP protocol.
        q.delete();
        put_eth(q, 16'h88A8); put_random(q, 30);
        send_frame(q, 1, 1, 1);
        q.delete();
        put_eth(q, ETYPE_IPV6); put_ipv6(q, 8'd1); put_random(q, 10);
        send_frame(q, 1, 1, 1);
        // Good headers on a non-Ethernet link.
        q.delete();
        put_eth(q, ETYPE_IPV4); put_ipv4(q, 5, PROTO_UDP); put_udp(q);
        send_frame(q, 1, 0, 1);
        // Too short, and one-byte frames with both markers on one beat.
        q.delete();
        put_random(q, 14);
        send_frame(q, 1, 1, 1);
        q.delete();
        put_random(q, 1);
        send_frame(q, 1, 1, 1);
        send_frame(q, 1, 0, 1);
        // GRE with every optional field, inner IPv6/UDP.
        q.delete();
        put_eth(q, ETYPE_IPV4); put_ipv4(q, 5, PROTO_GRE); put_gre(q, 16'hF000, ETYPE_IPV6);
        put_ipv6(q, PROTO_UDP); put_udp(q); put_random(q, 5);
        send_frame(q, 1, 1, 1);
        // Two nested tunnels ending in IPv6/TCP.
        q.delete();
        put_eth(q, ETYPE_IPV6); put_ipv6(q, PROTO_GRE); put_gre(q, 16'h0000, ETYPE_IPV4);
        put_ipv4(q, 6, PROTO_GRE); put_gre(q, 16'h2000, ETYPE_IPV6);
        put_ipv6(q, PROTO_TCP); put_tcp(q, 8); put_random(q, 2);
        send_frame(q, 1, 1, 1);
        // GRE carrying an unknown payload type.
        q.delete();
        put_eth(q, ETYPE_IPV4); put_ipv4(q, 5, PROTO_GRE); put_gre(q, 16'h8000, 16'h6558);
        put_random(q, 20);
        send_frame(q, 1, 1, 1);
        // Frames ending before the protocol, the data offset and the GRE type.
        q.delete();
        put_eth(q, ETYPE_IPV4); put_ipv4(q, 5, PROTO_TCP); cut_to(q, 23);
        send_frame(q, 1, 1, 1);
        q.delete();
        put_eth(q, ETYPE_IPV6); put_ipv6(q, PROTO_TCP); put_tcp(q, 5); cut_to(q, 66);
        send_frame(q, 1, 1, 1);
        q.delete();
        put_eth(q, ETYPE_IPV4); put_ipv4(q, 5, PROTO_GRE); put_gre(q, 16'h0000, ETYPE_IPV4);
        cut_to(q, 37);
        send_frame(q, 1, 1, 1);
        // Payload offset beyond the frame end.
        q.delete();
        put_eth(q, ETYPE_IPV4); put_ipv4(q, 5, PROTO_TCP); put_tcp(q, 15); cut_to(q, 64);
        send_frame(q, 1, 1, 1);
        // A first marker in mid-frame drops the partial frame.
        q.delete();
        put_eth(q, ETYPE_IPV4); put_ipv4(q, 5, PROTO_UDP);
        send_frame(q, 1, 1, 0);
        q.delete();
        put_eth(q, ETYPE_IPV6); put_ipv6(q, PROTO_UDP); put_udp(q); put_random(q, 9);
        send_frame(q, 1, 1, 1);
    endtask

    task automatic send_random_frames();
        octet_q_t q;
        int       pick;
        int       frames;
        frames = 0;
        while (bytes_sent < 2000)
        begin
            // A stretch with no idling; the receiver also holds off long enough to back up.
            if (frames == 3)
            begin
                quiet    = 1;
                hold_req = 400;
            end
            if (frames == 9)
                quiet = 0;
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                q.delete();
                put_random(q, $urandom_range(40, 1));
                send_frame(q, 1, 1'($urandom), 1);
            end
            else
            begin
                build_frame(q);
                if (pick < 13)
                    send_frame(q, 1, 0, 1);
                else if (pick < 18)
                    send_frame(q, 1, 1, 0);
                else if (pick < 23)
                    send_frame(q, 0, 1, 1);
                else
                    send_frame(q, 1, 1, 1);
            end
            frames++;
        end
        quiet = 0;
    endtask

    // Result side: sample at the rising edge, drive the stall at the falling edge.
    initial
    begin
        frame_layout_t got;
        int            hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got.st   = status;
                got.v6   = net_is_ipv6;
                got.udp  = transport_is_udp;
                got.gre  = gre_seen;
                got.ipo  = ip_offset;
                got.l4o  = transport_offset;
                got.payo = payload_start;
                got.plen = payload_length;
                tracker.check_layout(got);
            end
            @(negedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (quiet)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 25);
        end
    end

    // Reset, stimulus, drain and verdict.
    initial
    begin
        tracker          = new();
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        frame_byte       = 8'h00;
        first_byte       = 1'b0;
        last_byte        = 1'b0;
        link_is_ethernet = 1'b0;
        quiet            = 0;
        hold_req         = 0;
        bytes_sent       = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_directed_frames();
        send_random_frames();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (tracker.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
